// ----- rtl/ter_pkg.sv -----
// ----------------------------------------------------------------------------
// ter_pkg
// Shared widths, register indexes, sequencer codes and types of the
// triangle edge rasterizer.
// ----------------------------------------------------------------------------
package ter_pkg;

   localparam int TILE_SPAN = 64;
   localparam int FRAC_BITS = 4;

   localparam int COORD_W   = 16;
   localparam int PIX_W     = 12;
   localparam int DIM_W     = 13;
   localparam int ADDR_W    = 26;
   localparam int CSR_IDX_W = 2;

   // box bounds and walked columns; also holds tile start + span
   localparam int BOX_W   = (COORD_W - FRAC_BITS + 2 > 14) ? COORD_W - FRAC_BITS + 2 : 14;
   localparam int DELTA_W = COORD_W + 1;
   localparam int SUB_W   = BOX_W + FRAC_BITS + 1;
   localparam int PROD_W  = DELTA_W + SUB_W;
   localparam int EDGE_W  = PROD_W + 1;

   localparam int ADDR_SHIFT = 2;   // 4 bytes per pixel

   localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = DIM_W'(640);
   localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = DIM_W'(480);

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_W'(1);

   // multiply sequence: one product per step on the shared multiplier
   localparam int MUL_STEP_W = 3;
   localparam logic [MUL_STEP_W-1:0] MS_E0_POS   = 3'd0;
   localparam logic [MUL_STEP_W-1:0] MS_E0_NEG   = 3'd1;
   localparam logic [MUL_STEP_W-1:0] MS_E1_POS   = 3'd2;
   localparam logic [MUL_STEP_W-1:0] MS_E1_NEG   = 3'd3;
   localparam logic [MUL_STEP_W-1:0] MS_E2_POS   = 3'd4;
   localparam logic [MUL_STEP_W-1:0] MS_E2_NEG   = 3'd5;
   localparam logic [MUL_STEP_W-1:0] MS_ROW_BASE = 3'd6;
   localparam logic [MUL_STEP_W-1:0] MS_DONE     = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOX,
      ST_CLIP,
      ST_MUL,
      ST_WALK,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] a;
      logic signed [SUB_W-1:0]   b;
   } mul_op_type;

endpackage

// ----- rtl/ter_mul_unit.sv -----
// ----------------------------------------------------------------------------
// ter_mul_unit
// Shared signed multiplier with a registered product, used for the edge
// function setup and the row base address.
// ----------------------------------------------------------------------------
module ter_mul_unit
   import ter_pkg::*;
(
   input  logic                     clock,
   input  mul_op_type               op,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [DELTA_W-1:0] a_s;
   logic signed [SUB_W-1:0]   b_s;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;

   assign a_s     = op.a;
   assign b_s     = op.b;
   assign prod_in = a_s * b_s;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/triangle_edge_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer_unit
// Walks one row of a triangle's bounding box, clipped to a 64-pixel tile,
// and reports edge-function coverage and framebuffer address per pixel.
//
//   channel | direction | handshake          | contents
//   --------+-----------+--------------------+-------------------------------
//   req_    | in        | req_valid/stall    | three vertices, row, tile start
//   rsp_    | out       | rsp_valid/stall    | pixel, address, coverage, last
//   csr_    | in        | csr_valid/ready    | screen width / height writes
//
// A request is accepted, passes the box and clip states, then the shared
// multiplier (edge function products plus the row base address), then walks
// the span one pixel per cycle while rsp_stall does not freeze the walk;
// an empty span skips the multiplier. req_stall stays high until the last
// result is registered. Reset: idle, width 640, height 480.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer_unit
   import ter_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_W-1:0]   req_v0_x,
   input  logic signed [COORD_W-1:0]   req_v0_y,
   input  logic signed [COORD_W-1:0]   req_v1_x,
   input  logic signed [COORD_W-1:0]   req_v1_y,
   input  logic signed [COORD_W-1:0]   req_v2_x,
   input  logic signed [COORD_W-1:0]   req_v2_y,
   input  logic signed [PIX_W-1:0]     req_row_y,
   input  logic signed [PIX_W-1:0]     req_tile_x,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [PIX_W-1:0]     rsp_pixel_x,
   output logic signed [PIX_W-1:0]     rsp_pixel_y,
   output logic [ADDR_W-1:0]           rsp_byte_address,
   output logic                        rsp_covered,
   output logic                        rsp_write_enable,
   output logic                        rsp_span_nonempty,
   output logic                        rsp_last,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DIM_W-1:0]            csr_wdata
);

   localparam logic [COORD_W:0] FRAC_MASK = (COORD_W+1)'((1 << FRAC_BITS) - 1);

   function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   // truncate toward zero: bias negatives by one minus an ulp before the shift
   function automatic logic signed [BOX_W-1:0] trunc_fix(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] biased;
      biased = (COORD_W+1)'(v) + (v[COORD_W-1] ? FRAC_MASK : '0);
      return BOX_W'(biased >>> FRAC_BITS);
   endfunction

   // control
   state_type                 state_ff, state_in;
   logic [MUL_STEP_W-1:0]     step_ff;
   logic [DIM_W-1:0]          width_ff, height_ff;
   logic                      rsp_valid_ff;

   // request
   logic signed [COORD_W-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [PIX_W-1:0]   row_ff, tile_ff;

   // box and setup
   logic signed [BOX_W-1:0]   minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic signed [DELTA_W-1:0] dx0_ff, dx1_ff, dx2_ff, dy0_ff, dy1_ff, dy2_ff;
   logic signed [BOX_W-1:0]   x_ff, hi_ff;
   logic                      row_in_ff;
   logic signed [EDGE_W-1:0]  e0_ff, e1_ff, e2_ff;
   logic [ADDR_W-1:0]         addr_ff;

   // result register
   logic signed [PIX_W-1:0]   rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic [ADDR_W-1:0]         rsp_addr_ff;
   logic                      rsp_cov_ff, rsp_we_ff, rsp_ne_ff, rsp_last_ff;

   // combinational
   logic                      accept, out_free, busy, load_pix, load_empty;
   logic signed [BOX_W-1:0]   tile_ext, tile_end, row_ext, lo_c, hi_c, x_next;
   logic                      empty_c, row_in_c, inside_c, cov_c, last_pix;
   logic [BOX_W-1:0]          x_u;
   logic [PIX_W-1:0]          row_u;
   logic signed [SUB_W-1:0]   sx_c, sy_c;
   logic [MUL_STEP_W-1:0]     done_step;
   mul_op_type                mul_op;
   logic signed [PROD_W-1:0]  prod;

   ter_mul_unit u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_BOX;
         ST_BOX:   state_in = ST_CLIP;
         ST_CLIP:  state_in = empty_c ? ST_EMPTY : ST_MUL;
         ST_MUL:   if (step_ff == MS_DONE) state_in = ST_WALK;
         ST_WALK:  if (out_free && last_pix) state_in = ST_IDLE;
         ST_EMPTY: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      busy       = 1'b1;
      load_pix   = 1'b0;
      load_empty = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_WALK:  load_pix = out_free;
         ST_EMPTY: load_empty = out_free;
         default:  busy = 1'b1;
      endcase
   end

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // ---------------- clip / span decision ----------------
   always_comb begin
      tile_ext = BOX_W'(tile_ff);
      tile_end = tile_ext + BOX_W'(TILE_SPAN);
      row_ext  = BOX_W'(row_ff);
      lo_c     = (minx_ff > tile_ext) ? minx_ff : tile_ext;
      hi_c     = (maxx_ff < tile_end) ? maxx_ff : tile_end;
      empty_c  = (row_ext < miny_ff) || (row_ext >= maxy_ff) || (lo_c >= hi_c);
   end

   assign row_u    = row_ff;
   assign row_in_c = !row_ff[PIX_W-1] && (DIM_W'(row_u) < height_ff);

   // ---------------- multiplier operands ----------------
   assign sx_c      = SUB_W'(x_ff) <<< FRAC_BITS;
   assign sy_c      = SUB_W'(row_ff) <<< FRAC_BITS;
   assign done_step = step_ff - MUL_STEP_W'(1);

   always_comb begin
      mul_op.a = '0;
      mul_op.b = '0;
      case (step_ff)
         MS_E0_POS: begin
            mul_op.a = dy0_ff;
            mul_op.b = sx_c - SUB_W'(v0x_ff);
         end
         MS_E0_NEG: begin
            mul_op.a = dx0_ff;
            mul_op.b = sy_c - SUB_W'(v0y_ff);
         end
         MS_E1_POS: begin
            mul_op.a = dy1_ff;
            mul_op.b = sx_c - SUB_W'(v1x_ff);
         end
         MS_E1_NEG: begin
            mul_op.a = dx1_ff;
            mul_op.b = sy_c - SUB_W'(v1y_ff);
         end
         MS_E2_POS: begin
            mul_op.a = dy2_ff;
            mul_op.b = sx_c - SUB_W'(v2x_ff);
         end
         MS_E2_NEG: begin
            mul_op.a = dx2_ff;
            mul_op.b = sy_c - SUB_W'(v2y_ff);
         end
         MS_ROW_BASE: begin
            mul_op.a = DELTA_W'(width_ff);
            mul_op.b = SUB_W'(row_ff);
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   // ---------------- pixel ----------------
   assign x_u      = x_ff;
   assign x_next   = x_ff + BOX_W'(1);
   assign last_pix = (x_next == hi_ff);
   assign inside_c = row_in_ff && !x_ff[BOX_W-1] && (x_u < BOX_W'(width_ff));
   assign cov_c    = !e0_ff[EDGE_W-1] && !e1_ff[EDGE_W-1] && !e2_ff[EDGE_W-1];

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         width_ff     <= SCREEN_WIDTH_RST;
         height_ff    <= SCREEN_HEIGHT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLIP)
            step_ff <= '0;
         else if (state_ff == ST_MUL)
            step_ff <= step_ff + MUL_STEP_W'(1);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
               default:           ;
            endcase
         end
         if (load_pix || load_empty)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         v0x_ff  <= req_v0_x;
         v0y_ff  <= req_v0_y;
         v1x_ff  <= req_v1_x;
         v1y_ff  <= req_v1_y;
         v2x_ff  <= req_v2_x;
         v2y_ff  <= req_v2_y;
         row_ff  <= req_row_y;
         tile_ff <= req_tile_x;
      end

      if (state_ff == ST_BOX) begin
         minx_ff <= trunc_fix(min3(v0x_ff, v1x_ff, v2x_ff));
         maxx_ff <= trunc_fix(max3(v0x_ff, v1x_ff, v2x_ff));
         miny_ff <= trunc_fix(min3(v0y_ff, v1y_ff, v2y_ff));
         maxy_ff <= trunc_fix(max3(v0y_ff, v1y_ff, v2y_ff));
         dx0_ff  <= DELTA_W'(v1x_ff) - DELTA_W'(v0x_ff);
         dx1_ff  <= DELTA_W'(v2x_ff) - DELTA_W'(v1x_ff);
         dx2_ff  <= DELTA_W'(v0x_ff) - DELTA_W'(v2x_ff);
         dy0_ff  <= DELTA_W'(v1y_ff) - DELTA_W'(v0y_ff);
         dy1_ff  <= DELTA_W'(v2y_ff) - DELTA_W'(v1y_ff);
         dy2_ff  <= DELTA_W'(v0y_ff) - DELTA_W'(v2y_ff);
      end

      if (state_ff == ST_CLIP) begin
         x_ff      <= lo_c;
         hi_ff     <= hi_c;
         row_in_ff <= row_in_c;
      end

      // product of the previous step lands in the cycle after issue
      if (state_ff == ST_MUL && step_ff != MS_E0_POS) begin
         case (done_step)
            MS_E0_POS:   e0_ff <= EDGE_W'(prod);
            MS_E0_NEG:   e0_ff <= e0_ff - EDGE_W'(prod);
            MS_E1_POS:   e1_ff <= EDGE_W'(prod);
            MS_E1_NEG:   e1_ff <= e1_ff - EDGE_W'(prod);
            MS_E2_POS:   e2_ff <= EDGE_W'(prod);
            MS_E2_NEG:   e2_ff <= e2_ff - EDGE_W'(prod);
            MS_ROW_BASE: addr_ff <= (ADDR_W'(prod) + ADDR_W'(x_ff)) << ADDR_SHIFT;
            default:     ;
         endcase
      end

      if (load_pix) begin
         x_ff    <= x_next;
         e0_ff   <= e0_ff + (EDGE_W'(dy0_ff) <<< FRAC_BITS);
         e1_ff   <= e1_ff + (EDGE_W'(dy1_ff) <<< FRAC_BITS);
         e2_ff   <= e2_ff + (EDGE_W'(dy2_ff) <<< FRAC_BITS);
         addr_ff <= addr_ff + (ADDR_W'(1) << ADDR_SHIFT);

         rsp_pixel_x_ff <= x_ff[PIX_W-1:0];
         rsp_pixel_y_ff <= row_ff;
         rsp_addr_ff    <= inside_c ? addr_ff : '0;
         rsp_cov_ff     <= cov_c;
         rsp_we_ff      <= cov_c && inside_c;
         rsp_ne_ff      <= 1'b1;
         rsp_last_ff    <= last_pix;
      end else if (load_empty) begin
         rsp_pixel_x_ff <= tile_ff;
         rsp_pixel_y_ff <= row_ff;
         rsp_addr_ff    <= '0;
         rsp_cov_ff     <= 1'b0;
         rsp_we_ff      <= 1'b0;
         rsp_ne_ff      <= 1'b0;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = rsp_pixel_x_ff;
   assign rsp_pixel_y       = rsp_pixel_y_ff;
   assign rsp_byte_address  = rsp_addr_ff;
   assign rsp_covered       = rsp_cov_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_span_nonempty = rsp_ne_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef ASSERT_OFF
   // the walk never runs past the clipped end of the span
   a_walk_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (x_ff < hi_ff))
      else $error("pixel walk past span end");

   // an accepted request always starts with the box cycle
   a_accept_box: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_BOX))
      else $error("request accepted without entering box setup");

   // an empty-span result is always the only, hence last, result
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_span_nonempty) |-> (rsp_last && !rsp_write_enable))
      else $error("empty-span result not marked last");

   // write enable implies coverage
   a_we_cov: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_enable) |-> rsp_covered)
      else $error("write enabled on uncovered pixel");
`endif

endmodule

// ----- tb/triangle_edge_rasterizer_unit_test.sv -----
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer_unit_test
// Self-checking bench for the triangle edge rasterizer. A queue-fed driver
// sends triangle/row/tile requests, an in-bench span predictor expands each
// accepted request into its pixel results, and a monitor compares every
// result field by field. Screen size registers are swept between phases,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer_unit_test;
   import ter_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 10;
   localparam int ONE = 1 << FRAC_BITS;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_PRINTS = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(2);

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [PIX_W-1:0]   row_y;
      logic signed [PIX_W-1:0]   tile_x;
   } tri_req_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic [ADDR_W-1:0]       byte_address;
      logic                    covered;
      logic                    write_enable;
      logic                    span_nonempty;
      logic                    last;
   } pixel_rsp_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_v0_x, req_v0_y, req_v1_x, req_v1_y, req_v2_x, req_v2_y;
   logic signed [PIX_W-1:0]   req_row_y, req_tile_x;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [PIX_W-1:0]   rsp_pixel_x, rsp_pixel_y;
   logic [ADDR_W-1:0]         rsp_byte_address;
   logic                      rsp_covered, rsp_write_enable, rsp_span_nonempty, rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [DIM_W-1:0]          csr_wdata;

   tri_req_type   tri_queue[$];
   pixel_rsp_type pixel_expect[$];

   longint scr_width, scr_height;
   bit     idling, hold_go, long_hold;
   int     send_gap, stall_left, quiet;
   int     n_errors, n_requests, n_pixels, n_covered, n_written, n_empty, n_csr;

   triangle_edge_rasterizer_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_v0_x          (req_v0_x),
      .req_v0_y          (req_v0_y),
      .req_v1_x          (req_v1_x),
      .req_v1_y          (req_v1_y),
      .req_v2_x          (req_v2_x),
      .req_v2_y          (req_v2_y),
      .req_row_y         (req_row_y),
      .req_tile_x        (req_tile_x),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_covered       (rsp_covered),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_span_nonempty (rsp_span_nonempty),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // fixed point to integer pixel, rounding toward zero
   function automatic longint to_pixel(longint v);
      if (v >= 0) return v >>> FRAC_BITS;
      return -((-v) >>> FRAC_BITS);
   endfunction

   function automatic longint least_of(longint a, longint b, longint c);
      longint m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

   function automatic longint most_of(longint a, longint b, longint c);
      longint m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   task automatic predict_span(input tri_req_type r);
      longint x0, y0, x1, y1, x2, y2, row, tile;
      longint minx, maxx, miny, maxy, lo, hi, sy, sx, e0, e1, e2, x;
      bit row_in, on_screen, cov;
      pixel_rsp_type p;
      x0 = r.v0_x;
      y0 = r.v0_y;
      x1 = r.v1_x;
      y1 = r.v1_y;
      x2 = r.v2_x;
      y2 = r.v2_y;
      row = r.row_y;
      tile = r.tile_x;
      minx = to_pixel(least_of(x0, x1, x2));
      maxx = to_pixel(most_of(x0, x1, x2));
      miny = to_pixel(least_of(y0, y1, y2));
      maxy = to_pixel(most_of(y0, y1, y2));
      lo = (minx > tile) ? minx : tile;
      hi = (maxx < tile + TILE_SPAN) ? maxx : tile + TILE_SPAN;
      p = '0;
      p.pixel_y = row[PIX_W-1:0];
      if (row < miny || row >= maxy || lo >= hi) begin
         p.pixel_x = tile[PIX_W-1:0];
         p.last = 1'b1;
         pixel_expect.push_back(p);
         n_empty++;
         return;
      end
      sy = row * ONE;
      e0 = (x1 - x0) * (sy - y0);
      e1 = (x2 - x1) * (sy - y1);
      e2 = (x0 - x2) * (sy - y2);
      row_in = row >= 0 && row < scr_height;
      for (x = lo; x < hi; x++) begin
         sx = x * ONE;
         cov = e0 <= (y1 - y0) * (sx - x0) &&
               e1 <= (y2 - y1) * (sx - x1) &&
               e2 <= (y0 - y2) * (sx - x2);
         on_screen = row_in && x >= 0 && x < scr_width;
         p.pixel_x = x[PIX_W-1:0];
         p.byte_address = on_screen ? ADDR_W'((row * scr_width + x) << ADDR_SHIFT) : '0;
         p.covered = cov;
         p.write_enable = cov && on_screen;
         p.span_nonempty = 1'b1;
         p.last = (x + 1 == hi);
         pixel_expect.push_back(p);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic tri_req_type tri_of(int ax, int ay, int bx, int by, int cx, int cy,
                                          int row, int tile);
      tri_req_type r;
      r.v0_x = COORD_W'(ax);
      r.v0_y = COORD_W'(ay);
      r.v1_x = COORD_W'(bx);
      r.v1_y = COORD_W'(by);
      r.v2_x = COORD_W'(cx);
      r.v2_y = COORD_W'(cy);
      r.row_y = PIX_W'(row);
      r.tile_x = PIX_W'(tile);
      return r;
   endfunction

   // mostly small triangles with the row and tile placed over the box;
   // noise requests take any bit pattern and usually land on an empty span
   function automatic tri_req_type make_random_tri(bit noise);
      tri_req_type r;
      int cx, cy, rad, mnx, mny, mxy, k;
      int vx [3];
      int vy [3];
      if (noise) begin
         r.v0_x = COORD_W'($urandom);
         r.v0_y = COORD_W'($urandom);
         r.v1_x = COORD_W'($urandom);
         r.v1_y = COORD_W'($urandom);
         r.v2_x = COORD_W'($urandom);
         r.v2_y = COORD_W'($urandom);
         r.row_y = PIX_W'($urandom);
         r.tile_x = PIX_W'($urandom);
         return r;
      end
      rad = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 200))
                                         : int'($urandom_range(1, 40));
      cx = int'($urandom_range(0, 760)) - 60;
      cy = int'($urandom_range(0, 560)) - 40;
      for (k = 0; k < 3; k++) begin
         vx[k] = (cx + int'($urandom_range(0, 2 * rad)) - rad) * ONE
                 + int'($urandom_range(0, ONE - 1));
         vy[k] = (cy + int'($urandom_range(0, 2 * rad)) - rad) * ONE
                 + int'($urandom_range(0, ONE - 1));
      end
      mnx = vx[0];
      mny = vy[0];
      mxy = vy[0];
      for (k = 1; k < 3; k++) begin
         if (vx[k] < mnx) mnx = vx[k];
         if (vy[k] < mny) mny = vy[k];
         if (vy[k] > mxy) mxy = vy[k];
      end
      r = tri_of(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2],
                 (mny >>> FRAC_BITS) - 1
                    + int'($urandom_range(0, ((mxy - mny) >>> FRAC_BITS) + 2)),
                 (mnx >>> FRAC_BITS) - int'($urandom_range(0, 24))
                    + int'($urandom_range(0, 2 * rad)));
      return r;
   endfunction

   task automatic queue_random(input int count);
      int i;
      for (i = 0; i < count; i++)
         tri_queue.push_back(make_random_tri($urandom_range(0, 4) == 0));
   endtask

   task automatic queue_directed();
      // two windings of the same triangle
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 50*ONE, 10*ONE, 10*ONE, 40*ONE, 20, 0));
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 10*ONE, 40*ONE, 50*ONE, 10*ONE, 20, 0));
      // single point: empty box
      tri_queue.push_back(tri_of(5*ONE+3, 5*ONE+3, 5*ONE+3, 5*ONE+3, 5*ONE+3, 5*ONE+3, 5, 0));
      // zero area line: only pixels on the line are covered
      tri_queue.push_back(tri_of(0, 0, 40*ONE, 20*ONE, 80*ONE, 40*ONE, 10, 0));
      // row just above, at top, at exclusive bottom of the box
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 50*ONE, 10*ONE, 10*ONE, 40*ONE, 9, 0));
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 50*ONE, 10*ONE, 10*ONE, 40*ONE, 10, 0));
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 50*ONE, 10*ONE, 10*ONE, 40*ONE, 40, 0));
      // tile starts at the exclusive right bound, then one pixel before it
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 50*ONE, 10*ONE, 10*ONE, 40*ONE, 12, 50));
      tri_queue.push_back(tri_of(10*ONE, 10*ONE, 50*ONE, 10*ONE, 10*ONE, 40*ONE, 12, 49));
      // box wider than the tile: full 64 pixel walk
      tri_queue.push_back(tri_of(0, 0, 300*ONE, 5*ONE, 0, 60*ONE, 3, 64));
      // negative coordinates, truncation toward zero, off-screen pixels
      tri_queue.push_back(tri_of(-17, -40, -33*ONE+7, 30*ONE, 25*ONE+9, 2, -1, -10));
      tri_queue.push_back(tri_of(-30*ONE, -20*ONE, 20*ONE, -25*ONE, 5*ONE, 30*ONE, 3, -20));
      // span crossing the right screen edge
      tri_queue.push_back(tri_of(600*ONE, 90*ONE, 700*ONE, 100*ONE, 620*ONE, 130*ONE, 100, 610));
      // last row on screen, first row below it
      tri_queue.push_back(tri_of(100*ONE, 470*ONE, 160*ONE, 470*ONE, 130*ONE, 500*ONE, 479, 100));
      tri_queue.push_back(tri_of(100*ONE, 470*ONE, 160*ONE, 470*ONE, 130*ONE, 500*ONE, 480, 100));
      // coordinate and row/tile extremes
      tri_queue.push_back(tri_of(-32768, -32768, 32767, -32768, -32768, 32767, -2048, -2048));
      tri_queue.push_back(tri_of(32767, 32767, -32768, 32767, 32767, -32768, 2047, 2047));
      tri_queue.push_back(tri_of(32767, 32767, -32768, 32767, 32767, -32768, 2046, 1983));
      // all fraction bits set
      tri_queue.push_back(tri_of(15, 15, ONE+15, 15, 15, ONE+15, 0, 0));
   endtask

   task automatic wait_drained();
      while (tri_queue.size() != 0 || req_valid || pixel_expect.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_screen_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SCREEN_WIDTH) scr_width = val;
      else if (idx == CSR_SCREEN_HEIGHT) scr_height = val;
      n_csr++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_span(tri_queue.pop_front());
            n_requests++;
            if (idling && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 14);
         end
         if (req_valid && req_stall) begin
            // hold the offered request
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (tri_queue.size() > 0) begin
            {req_v0_x, req_v0_y, req_v1_x, req_v1_y, req_v2_x, req_v2_y,
             req_row_y, req_tile_x} <= tri_queue[0];
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTS) $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                   n_pixels, name, got, want));
   endtask

   always @(posedge clock) begin
      pixel_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected result at pixel_x %0d pixel_y %0d",
                                      rsp_pixel_x, rsp_pixel_y));
         end else begin
            want = pixel_expect.pop_front();
            check_field("pixel_x", rsp_pixel_x, want.pixel_x);
            check_field("pixel_y", rsp_pixel_y, want.pixel_y);
            check_field("byte_address", rsp_byte_address, want.byte_address);
            check_field("covered", rsp_covered, want.covered);
            check_field("write_enable", rsp_write_enable, want.write_enable);
            check_field("span_nonempty", rsp_span_nonempty, want.span_nonempty);
            check_field("last", rsp_last, want.last);
            n_covered += want.covered;
            n_written += want.write_enable;
         end
         n_pixels++;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long output hold-off so the block backs up into req_stall
   initial begin
      long_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("triangle_edge_rasterizer_unit test failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_v0_x, req_v0_y, req_v1_x, req_v1_y, req_v2_x, req_v2_y} = '0;
      req_row_y = '0;
      req_tile_x = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idling = 1'b1;
      hold_go = 1'b0;
      send_gap = 0;
      stall_left = 0;
      quiet = 0;
      scr_width = SCREEN_WIDTH_RST;
      scr_height = SCREEN_HEIGHT_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset screen size
      queue_directed();
      wait_drained();

      write_screen_reg(CSR_SCREEN_WIDTH, DIM_W'(4096));
      write_screen_reg(CSR_SCREEN_HEIGHT, DIM_W'(4096));
      hold_go = 1'b1;
      queue_random(30);
      wait_drained();

      write_screen_reg(CSR_SCREEN_WIDTH, DIM_W'(1));
      write_screen_reg(CSR_SCREEN_HEIGHT, DIM_W'(1));
      queue_random(15);
      wait_drained();

      // zero size: nothing is on screen; an unmapped index must change nothing
      write_screen_reg(CSR_SCREEN_WIDTH, DIM_W'(0));
      write_screen_reg(CSR_SCREEN_HEIGHT, DIM_W'(0));
      write_screen_reg(CSR_SPARE, DIM_W'(1234));
      queue_random(15);
      wait_drained();

      write_screen_reg(CSR_SCREEN_WIDTH, '1);
      write_screen_reg(CSR_SCREEN_HEIGHT, '1);
      queue_random(20);
      wait_drained();

      write_screen_reg(CSR_SCREEN_WIDTH, DIM_W'(320));
      write_screen_reg(CSR_SCREEN_HEIGHT, DIM_W'(200));
      idling = 1'b0;
      queue_random(35);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixel_expect.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", pixel_expect.size()));

      $display("Covered %0d triangle requests, %0d pixel results (%0d covered, %0d written),",
               n_requests, n_pixels, n_covered, n_written);
      $display("%0d empty spans, %0d register writes over six screen sizes, %0d errors",
               n_empty, n_csr, n_errors);
      if (n_errors == 0) begin
         $display("triangle_edge_rasterizer_unit test passed");
      end else begin
         $display("triangle_edge_rasterizer_unit test failed");
      end
      $finish;
   end

endmodule
